// ===== hdl/fcp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types and constants of the framed command parser.
// ----------------------------------------------------------------------------
package fcp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_START_CODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NACK_CODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SET_SPEED_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GET_STATS_CODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd6;

    localparam logic [BYTE_W-1:0] RST_START_CODE     = 8'd2;
    localparam logic [BYTE_W-1:0] RST_ACK_CODE       = 8'd6;
    localparam logic [BYTE_W-1:0] RST_NACK_CODE      = 8'd21;
    localparam logic [BYTE_W-1:0] RST_SET_SPEED_CODE = 8'd1;
    localparam logic [BYTE_W-1:0] RST_STOP_CODE      = 8'd2;
    localparam logic [BYTE_W-1:0] RST_GET_STATS_CODE = 8'd3;
    localparam logic [BYTE_W-1:0] RST_SPEED_LIMIT    = 8'd100;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] ack_code;
        logic [BYTE_W-1:0] nack_code;
        logic [BYTE_W-1:0] set_speed_code;
        logic [BYTE_W-1:0] stop_code;
        logic [BYTE_W-1:0] get_stats_code;
        logic [BYTE_W-1:0] speed_limit;
    } cfg_t;

    // One reply: a single code byte, or three statistics then the code byte.
    typedef struct packed {
        logic              stats;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] dropped;
        logic [BYTE_W-1:0] broken;
        logic [BYTE_W-1:0] errors;
        logic [BYTE_W-1:0] speed;
    } job_t;

endpackage

// ===== hdl/fcp_front.sv =====
// ----------------------------------------------------------------------------
// fcp_front
// Deframes received bytes, checks the XOR byte, runs the command on the
// speed and error state and hands one reply job per frame to the queue.
// ----------------------------------------------------------------------------
module fcp_front
    import fcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [BYTE_W-1:0] rx_data,
    input  logic [BYTE_W-1:0] dropped_count,
    input  logic [BYTE_W-1:0] broken_count,
    input  logic              q_full,
    output logic              push,
    output job_t              job
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_CMD  = 3'd2,
        PH_PAY  = 3'd3,
        PH_CHK  = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] first_reg, first_next;
    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic [BYTE_W-1:0] chk_reg, chk_next;
    logic [BYTE_W-1:0] speed_reg, speed_next;
    logic [BYTE_W-1:0] errs_reg, errs_next;
    logic [BYTE_W-1:0] pos_inc;
    logic              accept;

    // Only a check byte produces a job, so only it waits on a full queue.
    assign rx_stall = (phase_reg == PH_CHK) && q_full;
    assign accept   = rx_valid && !rx_stall;
    assign pos_inc  = pos_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        cmd_next    = cmd_reg;
        first_next  = first_reg;
        pos_next    = pos_reg;
        chk_next    = chk_reg;
        speed_next  = speed_reg;
        errs_next   = errs_reg;
        push        = 1'b0;
        job.stats   = 1'b0;
        job.code    = cfg.nack_code;
        job.dropped = dropped_count;
        job.broken  = broken_count;
        job.errors  = errs_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    len_next   = rx_data;
                    pos_next   = '0;
                    chk_next   = chk_reg ^ rx_data;
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = rx_data;
                    chk_next   = chk_reg ^ rx_data;
                    phase_next = (len_reg > 8'd1) ? PH_PAY : PH_CHK;
                end
                PH_PAY:
                begin
                    if (pos_reg == '0)
                    begin
                        first_next = rx_data;
                    end
                    pos_next = pos_inc;
                    chk_next = chk_reg ^ rx_data;
                    if (pos_inc == len_reg - 8'd1)
                    begin
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK:
                begin
                    push       = 1'b1;
                    phase_next = PH_IDLE;
                    if (chk_reg == rx_data)
                    begin
                        priority if (cmd_reg == cfg.set_speed_code)
                        begin
                            if (first_reg <= cfg.speed_limit)
                            begin
                                speed_next = first_reg;
                                job.code   = cfg.ack_code;
                            end
                        end
                        else if (cmd_reg == cfg.stop_code)
                        begin
                            speed_next = '0;
                            job.code   = cfg.ack_code;
                        end
                        else if (cmd_reg == cfg.get_stats_code)
                        begin
                            job.stats = 1'b1;
                            job.code  = cfg.ack_code;
                        end
                        else
                        begin
                            job.code = cfg.nack_code;
                        end
                    end
                    else
                    begin
                        errs_next = errs_reg + 8'd1;
                    end
                end
                default:
                begin
                    if (rx_data == cfg.start_code)
                    begin
                        phase_next = PH_LEN;
                        chk_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
        job.speed = speed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            cmd_reg   <= '0;
            first_reg <= '0;
            pos_reg   <= '0;
            chk_reg   <= '0;
            speed_reg <= '0;
            errs_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            first_reg <= first_next;
            pos_reg   <= pos_next;
            chk_reg   <= chk_next;
            speed_reg <= speed_next;
            errs_reg  <= errs_next;
        end
    end

endmodule

// ===== hdl/fcp_queue.sv =====
// ----------------------------------------------------------------------------
// fcp_queue
// Short job queue between the frame parser and the reply sender.
// ----------------------------------------------------------------------------
module fcp_queue
    import fcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("job popped from empty queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

// ===== hdl/fcp_back.sv =====
// ----------------------------------------------------------------------------
// fcp_back
// Expands the job at the queue head into reply bytes, one per cycle while
// tx_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module fcp_back
    import fcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  job_t              head,
    output logic              pop,
    output logic              tx_valid,
    input  logic              tx_stall,
    output logic [BYTE_W-1:0] tx_data,
    output logic              last,
    output logic [BYTE_W-1:0] speed_value
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic [BYTE_W-1:0] speed_reg, speed_next;
    logic [1:0]        idx_reg, idx_next;
    logic              load;
    logic              fin;
    logic [BYTE_W-1:0] byte_sel;

    assign load = !valid_reg || !tx_stall;
    assign fin  = !head.stats || (idx_reg == 2'd3);
    assign pop  = load && head_valid && fin;

    always_comb
    begin
        if (!head.stats)
        begin
            byte_sel = head.code;
        end
        else
        begin
            unique case (idx_reg)
                2'd0:    byte_sel = head.dropped;
                2'd1:    byte_sel = head.broken;
                2'd2:    byte_sel = head.errors;
                default: byte_sel = head.code;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        speed_next = speed_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                data_next  = byte_sel;
                last_next  = fin;
                speed_next = head.speed;
                idx_next   = fin ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        last_reg  <= last_next;
        speed_reg <= speed_next;
    end

    assign tx_valid    = valid_reg;
    assign tx_data     = data_reg;
    assign last        = last_reg;
    assign speed_value = speed_reg;

    a_idx_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> (head_valid && head.stats))
        else $error("statistics reply index set without statistics job");

endmodule

// ===== hdl/framed_command_parser_xor.sv =====
// ----------------------------------------------------------------------------
// framed_command_parser_xor
// Start/length framed command parser with XOR check byte and reply sender.
// ----------------------------------------------------------------------------
// One received byte is accepted per cycle; rx_stall rises only on a check
// byte while the two-entry reply queue is full. Each good or bad frame
// queues one reply job; the sender drains it one byte per cycle while
// tx_stall is low, through a registered output; a reply is one byte or
// four (statistics). A frame is at least four bytes, so with tx_stall low
// the queue never fills. Configuration registers are written through
// cfg_we, cfg_index and cfg_data; indexes past the last one are ignored.
module framed_command_parser_xor
    import fcp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  logic [BYTE_W-1:0]    rx_data,
    input  logic [BYTE_W-1:0]    dropped_count,
    input  logic [BYTE_W-1:0]    broken_count,
    output logic                 tx_valid,
    input  logic                 tx_stall,
    output logic [BYTE_W-1:0]    tx_data,
    output logic                 last,
    output logic [BYTE_W-1:0]    speed_value
);

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_CODE:     cfg_next.start_code     = cfg_data;
                REG_ACK_CODE:       cfg_next.ack_code       = cfg_data;
                REG_NACK_CODE:      cfg_next.nack_code      = cfg_data;
                REG_SET_SPEED_CODE: cfg_next.set_speed_code = cfg_data;
                REG_STOP_CODE:      cfg_next.stop_code      = cfg_data;
                REG_GET_STATS_CODE: cfg_next.get_stats_code = cfg_data;
                REG_SPEED_LIMIT:    cfg_next.speed_limit    = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code     <= RST_START_CODE;
            cfg_reg.ack_code       <= RST_ACK_CODE;
            cfg_reg.nack_code      <= RST_NACK_CODE;
            cfg_reg.set_speed_code <= RST_SET_SPEED_CODE;
            cfg_reg.stop_code      <= RST_STOP_CODE;
            cfg_reg.get_stats_code <= RST_GET_STATS_CODE;
            cfg_reg.speed_limit    <= RST_SPEED_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fcp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_data       (rx_data),
        .dropped_count (dropped_count),
        .broken_count  (broken_count),
        .q_full        (q_full),
        .push          (push),
        .job           (push_job)
    );

    fcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    fcp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .tx_valid    (tx_valid),
        .tx_stall    (tx_stall),
        .tx_data     (tx_data),
        .last        (last),
        .speed_value (speed_value)
    );

endmodule
